/* src/brq_pkg.sv */
// shared types, codes and constants of the batched retry queue
package brq_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int BATCH_MAX_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 64;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT    = 2'd3;

  localparam logic [2:0] REQ_SAMPLE = 3'd0;
  localparam logic [2:0] REQ_POLL   = 3'd1;
  localparam logic [2:0] REQ_TELE   = 3'd2;
  localparam logic [2:0] REQ_BEAT   = 3'd3;
  localparam logic [2:0] REQ_FLUSH  = 3'd4;

  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_ITEM   = 2'd1;
  localparam logic [1:0] ACT_BEAT   = 2'd2;

  localparam logic [2:0] STS_DISABLED = 3'd0;
  localparam logic [2:0] STS_WAITING  = 3'd1;
  localparam logic [2:0] STS_IDLE     = 3'd2;
  localparam logic [2:0] STS_QUEUEING = 3'd3;
  localparam logic [2:0] STS_BACKOFF  = 3'd4;
  localparam logic [2:0] STS_SEND_TEL = 3'd5;
  localparam logic [2:0] STS_SEND_HB  = 3'd6;

  localparam logic [2:0] STREAK_MAX = 3'd4;

  typedef enum logic [2:0] {
    K_SAMPLE, K_POLL, K_TELE, K_BEAT, K_FLUSH, K_OTHER
  } req_kind_t;

  typedef struct packed {
    logic             valid;
    req_kind_t        kind;
    logic [TIME_W-1:0] now;
    logic             link;
    logic             ok;
  } req_ctl_t;

  typedef struct packed {
    logic             en;
    logic [CFG_W-1:0] attempt;
    logic [CFG_W-1:0] retry;
    logic [CFG_W-1:0] beat;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_COPY_RD, S_COPY_WR, S_EMIT_RD, S_EMIT_WR,
    S_DISC_RD, S_DISC_CHK, S_PUT
  } back_state_t;

  function automatic logic [TIME_W-1:0] backoff_ms(input logic [2:0] streak);
    logic [TIME_W-1:0] v;
    unique case (streak)
      3'd2:    v = 32'd6000;
      3'd3:    v = 32'd12000;
      3'd4:    v = 32'd30000;
      default: v = 32'd3000;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] plain_status(input logic en, input logic nonempty,
                                              input logic failing);
    logic [2:0] s;
    if (!en) s = STS_DISABLED;
    else if (nonempty) s = failing ? STS_BACKOFF : STS_QUEUEING;
    else s = STS_IDLE;
    return s;
  endfunction

endpackage

/* src/brq_if.sv */
// request and result channel interfaces
interface brq_in_if #(parameter int DATA_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic [2:0]            req_type;
  logic [31:0]           now_ms;
  logic [DATA_WIDTH-1:0] sample_data;
  logic                  link_ready;
  logic                  send_ok;
  modport source (output valid, req_type, now_ms, sample_data, link_ready, send_ok,
                  input ready);
  modport sink (input valid, req_type, now_ms, sample_data, link_ready, send_ok,
                output ready);
endinterface

interface brq_out_if #(parameter int DATA_WIDTH = 64, parameter int DEPTH_W = 7);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [DATA_WIDTH-1:0] item_data;
  logic [31:0]           item_sequence;
  logic                  last_item;
  logic [2:0]            sender_status;
  logic [DEPTH_W-1:0]    queue_depth;
  logic [31:0]           dropped_total;
  modport source (output valid, action, item_data, item_sequence, last_item,
                  sender_status, queue_depth, dropped_total, input ready);
  modport sink (input valid, action, item_data, item_sequence, last_item,
                sender_status, queue_depth, dropped_total, output ready);
endinterface

/* src/brq_front.sv */
// front end: accepts requests, classifies them and holds two in a small queue
module brq_front #(
  parameter int DATA_WIDTH = brq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  brq_in_if.sink                in_chan,
  input  logic                  pop,
  output brq_pkg::req_ctl_t     req,
  output logic [DATA_WIDTH-1:0] req_data
);
  import brq_pkg::*;

  req_ctl_t              q_ctl_r  [2];
  logic [DATA_WIDTH-1:0] q_data_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;
  logic                  push;
  req_kind_t             kind;

  always_comb begin
    unique case (in_chan.req_type)
      REQ_SAMPLE: kind = K_SAMPLE;
      REQ_POLL:   kind = K_POLL;
      REQ_TELE:   kind = K_TELE;
      REQ_BEAT:   kind = K_BEAT;
      REQ_FLUSH:  kind = K_FLUSH;
      default:    kind = K_OTHER;
    endcase
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl_r[wp_r]  <= '{valid: 1'b1, kind: kind, now: in_chan.now_ms,
                         link: in_chan.link_ready, ok: in_chan.send_ok};
      q_data_r[wp_r] <= in_chan.sample_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_comb begin
    req       = q_ctl_r[rp_r];
    req.valid = (cnt_r != 2'd0);
    req_data  = q_data_r[rp_r];
  end

endmodule

/* src/brq_back.sv */
// back end: ring and batch stores, scheduling and result sequencing
module brq_back #(
  parameter int RING_DEPTH = brq_pkg::RING_DEPTH_DEF,
  parameter int BATCH_MAX  = brq_pkg::BATCH_MAX_DEF,
  parameter int DATA_WIDTH = brq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  brq_pkg::cfg_t         cfg,
  input  brq_pkg::req_ctl_t     req,
  input  logic [DATA_WIDTH-1:0] req_data,
  output logic                  pop,
  brq_out_if.source             out_chan
);
  import brq_pkg::*;

  localparam int RW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int BI = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
  localparam int BW = $clog2(BATCH_MAX + 1);
  localparam int EW = DATA_WIDTH + TIME_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

  logic [EW-1:0] ring_mem  [RING_DEPTH];
  logic [EW-1:0] batch_mem [BATCH_MAX];
  logic [EW-1:0] ring_q_r, batch_q_r;

  back_state_t           state_r, state_nxt;
  req_ctl_t              wk_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic [RW-1:0]         head_r, rptr_r;
  logic [CW-1:0]         count_r;
  logic [BW-1:0]         bc_r;
  logic [BI-1:0]         ci_r, ei_r;
  logic [TIME_W-1:0]     bls_r, nseq_r, due_r, beat_r, drop_r;
  logic [2:0]            streak_r, stat_r;
  logic [1:0]            act_r;
  logic                  plain_r;

  logic                  can_put, put_item, put_stat;
  logic                  full, ring_we, batch_we;
  logic [RW-1:0]         tail, head_inc, rptr_inc;
  logic [CW:0]           tail_sum;
  logic [TIME_W-1:0]     due_p, due_diff, beat_diff, now_att, q_seq, disc_diff;
  logic                  tele_go, beat_go, copy_last, emit_last, disc_keep;
  logic [BW-1:0]         bc_new;
  logic [2:0]            streak_n;

  function automatic logic [RW-1:0] inc_ptr(input logic [RW-1:0] p);
    logic [RW:0] t;
    t = {1'b0, p} + 1'b1;
    return (t == (RW+1)'(RING_DEPTH)) ? '0 : t[RW-1:0];
  endfunction

  assign can_put   = !out_chan.valid || out_chan.ready;
  assign full      = (count_r == DEPTH_C);
  assign head_inc  = inc_ptr(head_r);
  assign rptr_inc  = inc_ptr(rptr_r);
  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  // when full the new entry lands where the oldest one was
  assign tail      = full ? head_r :
                     (tail_sum >= (CW+1)'(RING_DEPTH)) ?
                     RW'(tail_sum - (CW+1)'(RING_DEPTH)) : RW'(tail_sum);
  assign now_att   = wk_r.now + TIME_W'(cfg.attempt);
  assign due_p     = (cfg.en && count_r != '0 && due_r == '0) ?
                     wk_r.now + TIME_W'((bc_r != '0) ? cfg.retry : cfg.attempt) : due_r;
  assign due_diff  = wk_r.now - due_p;
  assign tele_go   = (count_r != '0) && (due_p != '0) && !due_diff[TIME_W-1];
  assign beat_diff = wk_r.now - beat_r;
  assign beat_go   = !beat_diff[TIME_W-1] && (beat_diff >= TIME_W'(cfg.beat));
  assign bc_new    = (32'(count_r) < BATCH_MAX) ? BW'(count_r) : BW'(BATCH_MAX);
  assign copy_last = (BW'(ci_r) + 1'b1 == bc_r);
  assign emit_last = (BW'(ei_r) + 1'b1 == bc_r);
  assign q_seq     = ring_q_r[EW-1 -: TIME_W];
  assign disc_diff = bls_r - q_seq;
  assign disc_keep = (count_r != '0) && !disc_diff[TIME_W-1];
  assign streak_n  = (streak_r < STREAK_MAX) ? streak_r + 3'd1 : streak_r;
  assign ring_we   = (state_r == S_DECODE) && (wk_r.kind == K_SAMPLE) && cfg.en;
  assign batch_we  = (state_r == S_COPY_WR);

  // memories, registered read
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[tail] <= {nseq_r, wdata_r};
    ring_q_r <= ring_mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (batch_we) batch_mem[ci_r] <= ring_q_r;
    batch_q_r <= batch_mem[ei_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (req.valid) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt = S_PUT;
        if (wk_r.kind == K_POLL && cfg.en && wk_r.link && tele_go)
          state_nxt = (bc_r == '0) ? S_COPY_RD : S_EMIT_RD;
        else if (wk_r.kind == K_TELE && bc_r != '0 && wk_r.ok)
          state_nxt = S_DISC_RD;
      end
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = copy_last ? S_EMIT_RD : S_COPY_RD;
      S_EMIT_RD:  state_nxt = S_EMIT_WR;
      S_EMIT_WR:  if (can_put) state_nxt = emit_last ? S_IDLE : S_EMIT_RD;
      S_DISC_RD:  state_nxt = S_DISC_CHK;
      S_DISC_CHK: state_nxt = disc_keep ? S_DISC_RD : S_PUT;
      S_PUT:      if (can_put) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_r == S_IDLE) && req.valid;
    put_item = (state_r == S_EMIT_WR) && can_put;
    put_stat = (state_r == S_PUT) && can_put;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      wk_r    <= req;
      wdata_r <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      bc_r     <= '0;
      bls_r    <= '0;
      nseq_r   <= '0;
      due_r    <= '0;
      beat_r   <= '0;
      streak_r <= '0;
      drop_r   <= '0;
      rptr_r   <= '0;
      ci_r     <= '0;
      ei_r     <= '0;
      stat_r   <= STS_DISABLED;
      act_r    <= ACT_STATUS;
      plain_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_DECODE: begin
          act_r   <= ACT_STATUS;
          plain_r <= 1'b1;
          unique case (wk_r.kind)
            K_SAMPLE: if (cfg.en) begin
              if (full) begin
                head_r <= head_inc;
                drop_r <= drop_r + 1'b1;
              end else begin
                count_r <= count_r + 1'b1;
              end
              nseq_r <= nseq_r + 1'b1;
              if (due_r == '0 && bc_r == '0) due_r <= now_att;
            end
            K_POLL: begin
              due_r <= due_p;
              if (!cfg.en) begin
                plain_r <= 1'b0;
                stat_r  <= STS_DISABLED;
              end else if (!wk_r.link) begin
                plain_r <= 1'b0;
                stat_r  <= STS_WAITING;
              end else if (tele_go) begin
                if (bc_r == '0) bc_r <= bc_new;
                ci_r   <= '0;
                ei_r   <= '0;
                rptr_r <= head_r;
              end else if (beat_go) begin
                beat_r  <= wk_r.now;
                act_r   <= ACT_BEAT;
                plain_r <= 1'b0;
                stat_r  <= STS_SEND_HB;
              end
            end
            K_TELE: if (bc_r != '0) begin
              if (wk_r.ok) begin
                rptr_r <= head_r;
              end else begin
                streak_r <= streak_n;
                due_r    <= wk_r.now + backoff_ms(streak_n);
                plain_r  <= 1'b0;
                stat_r   <= STS_BACKOFF;
              end
            end
            K_BEAT: begin
              plain_r <= 1'b0;
              stat_r  <= (count_r != '0) ? STS_QUEUEING : STS_IDLE;
            end
            K_FLUSH: begin
              head_r   <= '0;
              count_r  <= '0;
              bc_r     <= '0;
              bls_r    <= '0;
              due_r    <= '0;
              streak_r <= '0;
              plain_r  <= 1'b0;
              stat_r   <= cfg.en ? STS_IDLE : STS_DISABLED;
            end
            default: ;
          endcase
        end
        S_COPY_WR: begin
          if (copy_last) begin
            bls_r <= q_seq;
            ei_r  <= '0;
          end else begin
            ci_r   <= ci_r + 1'b1;
            rptr_r <= rptr_inc;
          end
        end
        S_EMIT_WR: if (can_put && !emit_last) ei_r <= ei_r + 1'b1;
        S_DISC_CHK: begin
          if (disc_keep) begin
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
            rptr_r  <= head_inc;
          end else begin
            bc_r     <= '0;
            bls_r    <= '0;
            streak_r <= '0;
            due_r    <= (count_r != '0) ? now_att : '0;
            plain_r  <= 1'b0;
            stat_r   <= (count_r != '0) ? STS_QUEUEING : STS_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_chan.valid <= 1'b0;
    end else if (put_item || put_stat) begin
      out_chan.valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_item) begin
      out_chan.action        <= ACT_ITEM;
      out_chan.item_data     <= batch_q_r[DATA_WIDTH-1:0];
      out_chan.item_sequence <= batch_q_r[EW-1 -: TIME_W];
      out_chan.last_item     <= emit_last;
      out_chan.sender_status <= STS_SEND_TEL;
      out_chan.queue_depth   <= count_r;
      out_chan.dropped_total <= drop_r;
    end else if (put_stat) begin
      out_chan.action        <= act_r;
      out_chan.item_data     <= '0;
      out_chan.item_sequence <= '0;
      out_chan.last_item     <= 1'b1;
      out_chan.sender_status <= plain_r ?
                                plain_status(cfg.en, count_r != '0, streak_r != '0) : stat_r;
      out_chan.queue_depth   <= count_r;
      out_chan.dropped_total <= drop_r;
    end
  end

endmodule

/* src/batched_retry_queue_with_backoff.sv */
// top level of the batched retry queue: configuration registers and the two halves
//
// Requests come in on in_chan (sample, poll, telemetry outcome, heartbeat
// outcome, flush) and every request yields one or more results on out_chan;
// last_item marks the final result of a request. Registers are written through
// cfg_we / cfg_index / cfg_wdata by the user, who must do so only while the block
// is idle; the block does not enforce it. A two-entry request queue sits in front
// of the sequencer, so requests are taken while a result still waits on a stalled
// receiver. A poll that builds a new batch copies each entry (read, then write),
// then emits each item (registered batch memory read, then output); a resend skips
// the copy. A successful outcome walks the ring with a read and a check per
// discarded entry. A stalled receiver holds the sequencer in place; nothing is lost.
// Synchronous reset empties ring and batch, clears all counters, the schedule
// and the failure streak and disables the sender; ring and batch contents need
// no clearing.
module batched_retry_queue_with_backoff #(
  parameter int RING_DEPTH = brq_pkg::RING_DEPTH_DEF,
  parameter int BATCH_MAX  = brq_pkg::BATCH_MAX_DEF,
  parameter int DATA_WIDTH = brq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  brq_in_if.sink                        in_chan,
  brq_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [brq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brq_pkg::CFG_W-1:0]     cfg_wdata
);
  import brq_pkg::*;

  cfg_t                  cfg_r;
  req_ctl_t              req;
  logic [DATA_WIDTH-1:0] req_data;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{en: 1'b0, attempt: 20'd1000, retry: 20'd3000, beat: 20'd60000};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  cfg_r.en      <= cfg_wdata[0];
        REG_ATTEMPT: cfg_r.attempt <= cfg_wdata;
        REG_RETRY:   cfg_r.retry   <= cfg_wdata;
        REG_BEAT:    cfg_r.beat    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  brq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .pop      (pop),
    .req      (req),
    .req_data (req_data)
  );

  brq_back #(
    .RING_DEPTH (RING_DEPTH),
    .BATCH_MAX  (BATCH_MAX),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .req      (req),
    .req_data (req_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

/* tb/sv/tb_batched_retry_queue_with_backoff.sv */
// testbench for the batched retry queue: directed and random requests checked against a predictor
module tb_batched_retry_queue_with_backoff;
  import brq_pkg::*;

  localparam int RD = 64;
  localparam int BM = 16;

  typedef struct {
    logic [1:0]  action;
    logic [63:0] data;
    logic [31:0] seq;
    logic        last;
    logic [2:0]  status;
    logic [6:0]  depth;
    logic [31:0] dropped;
  } result_t;

  class queue_scoreboard;
    result_t     pending[$];
    int          errors;
    // predictor state
    logic [63:0] rdata[RD];
    logic [31:0] rseq[RD];
    int          head, count;
    logic [63:0] bdata[BM];
    logic [31:0] bseq[BM];
    int          bcount;
    logic [31:0] blast, nseq, due, lastbeat, drops;
    int          streak;
    logic        en;
    logic [19:0] attempt, retry, beat;

    function new();
      head = 0; count = 0; bcount = 0; blast = 0; nseq = 0; due = 0;
      lastbeat = 0; streak = 0; drops = 0; en = 0;
      attempt = 1000; retry = 3000; beat = 60000; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] v);
      case (idx)
        REG_ENABLE:  en = v[0];
        REG_ATTEMPT: attempt = v;
        REG_RETRY:   retry = v;
        REG_BEAT:    beat = v;
      endcase
    endfunction

    function void emit(logic [1:0] a, logic [63:0] d, logic [31:0] s, logic l,
                       logic [2:0] st);
      result_t r;
      r.action = a; r.data = d; r.seq = s; r.last = l; r.status = st;
      r.depth = count[6:0]; r.dropped = drops;
      pending.push_back(r);
    endfunction

    function logic [2:0] status_now();
      if (!en) return STS_DISABLED;
      if (count > 0) return streak > 0 ? STS_BACKOFF : STS_QUEUEING;
      return STS_IDLE;
    endfunction

    function logic [31:0] backoff(int s);
      case (s)
        2: return 32'd6000;
        3: return 32'd12000;
        4: return 32'd30000;
        default: return 32'd3000;
      endcase
    endfunction

    function void note_request(logic [2:0] rt, logic [31:0] now, logic [63:0] d,
                               logic link, logic ok);
      logic [31:0] diff;
      int tail;
      case (rt)
        REQ_SAMPLE: begin
          if (en) begin
            if (count >= RD) begin
              head = (head + 1) % RD; count = RD - 1; drops++;
            end
            tail = (head + count) % RD;
            rdata[tail] = d; rseq[tail] = nseq; nseq++; count++;
            if (due == 0 && bcount == 0) due = now + attempt;
          end
          emit(ACT_STATUS, 0, 0, 1, status_now());
        end
        REQ_POLL: begin
          if (en && count > 0 && due == 0) due = now + (bcount > 0 ? retry : attempt);
          diff = now - due;
          if (!en) emit(ACT_STATUS, 0, 0, 1, STS_DISABLED);
          else if (!link) emit(ACT_STATUS, 0, 0, 1, STS_WAITING);
          else if (count > 0 && due != 0 && !diff[31]) begin
            if (bcount == 0) begin
              bcount = count < BM ? count : BM;
              for (int i = 0; i < bcount; i++) begin
                bdata[i] = rdata[(head + i) % RD]; bseq[i] = rseq[(head + i) % RD];
              end
              blast = bseq[bcount - 1];
            end
            for (int i = 0; i < bcount; i++)
              emit(ACT_ITEM, bdata[i], bseq[i], i + 1 == bcount, STS_SEND_TEL);
          end else begin
            diff = now - lastbeat;
            if (!diff[31] && diff >= {12'd0, beat}) begin
              lastbeat = now;
              emit(ACT_BEAT, 0, 0, 1, STS_SEND_HB);
            end else emit(ACT_STATUS, 0, 0, 1, status_now());
          end
        end
        REQ_TELE: begin
          if (bcount > 0) begin
            if (ok) begin
              while (count > 0) begin
                diff = blast - rseq[head];
                if (diff[31]) break;
                head = (head + 1) % RD; count--;
              end
              bcount = 0; blast = 0; streak = 0;
              due = count > 0 ? now + attempt : 0;
              emit(ACT_STATUS, 0, 0, 1, count > 0 ? STS_QUEUEING : STS_IDLE);
            end else begin
              if (streak < 4) streak++;
              due = now + backoff(streak);
              emit(ACT_STATUS, 0, 0, 1, STS_BACKOFF);
            end
          end else emit(ACT_STATUS, 0, 0, 1, status_now());
        end
        REQ_BEAT: emit(ACT_STATUS, 0, 0, 1, count > 0 ? STS_QUEUEING : STS_IDLE);
        REQ_FLUSH: begin
          head = 0; count = 0; bcount = 0; blast = 0; due = 0; streak = 0;
          emit(ACT_STATUS, 0, 0, 1, en ? STS_IDLE : STS_DISABLED);
        end
        default: emit(ACT_STATUS, 0, 0, 1, status_now());
      endcase
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $display("%0t unexpected result action=%0d seq=%0d", $time, got.action, got.seq);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.action !== w.action || got.data !== w.data || got.seq !== w.seq ||
          got.last !== w.last || got.status !== w.status || got.depth !== w.depth ||
          got.dropped !== w.dropped) begin
        $display("%0t mismatch expected a=%0d d=%h s=%0d l=%0d st=%0d q=%0d dr=%0d",
                 $time, w.action, w.data, w.seq, w.last, w.status, w.depth, w.dropped);
        $display("%0t          actual   a=%0d d=%h s=%0d l=%0d st=%0d q=%0d dr=%0d",
                 $time, got.action, got.data, got.seq, got.last, got.status, got.depth,
                 got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_ENABLE;
  logic [19:0] cfg_wdata = 0;
  logic        hold_off = 0;
  logic [31:0] clock_ms = 0;

  brq_in_if  #(.DATA_WIDTH(64)) in_chan ();
  brq_out_if #(.DATA_WIDTH(64), .DEPTH_W(7)) out_chan ();

  batched_retry_queue_with_backoff u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  queue_scoreboard sb = new();

  initial begin
    forever #5 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // result side: random ready, with a long hold-off when asked
  initial begin
    int g;
    result_t r;
    out_chan.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 0;
        @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_chan.ready <= 0;
          repeat (g) @(posedge clk);
        end
        out_chan.ready <= 1;
        @(posedge clk);
        if (out_chan.valid && out_chan.ready) begin
          r.action = out_chan.action; r.data = out_chan.item_data;
          r.seq = out_chan.item_sequence; r.last = out_chan.last_item;
          r.status = out_chan.sender_status; r.depth = out_chan.queue_depth;
          r.dropped = out_chan.dropped_total;
          sb.check_result(r);
        end
      end
    end
  end

  task automatic send_request(logic [2:0] rt, logic [31:0] now, logic [63:0] d,
                              logic link, logic ok, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_chan.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_chan.valid <= 1; in_chan.req_type <= rt; in_chan.now_ms <= now;
    in_chan.sample_data <= d; in_chan.link_ready <= link; in_chan.send_ok <= ok;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(rt, now, d, link, ok);
  endtask

  task automatic go_idle();
    in_chan.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly forward time; sometimes a jump, sometimes a random value
  function logic [31:0] step_time();
    case ($urandom_range(0, 9))
      0: clock_ms = $urandom();
      1: clock_ms = clock_ms + $urandom_range(20000, 70000);
      default: clock_ms = clock_ms + $urandom_range(0, 2500);
    endcase
    return clock_ms;
  endfunction

  task automatic random_phase(int n, int sample_weight);
    logic [2:0] rt;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < sample_weight) rt = REQ_SAMPLE;
      else if (k < sample_weight + 20) rt = REQ_POLL;
      else if (k < sample_weight + 35) rt = REQ_TELE;
      else if (k < sample_weight + 40) rt = REQ_BEAT;
      else if (k < sample_weight + 43) rt = REQ_FLUSH;
      else if (k < sample_weight + 46) rt = 3'($urandom_range(5, 7));
      else rt = REQ_POLL;
      send_request(rt, step_time(), rand64(), $urandom_range(0, 5) != 0,
                   $urandom_range(0, 2) != 0, 1);
    end
  endtask

  initial begin
    in_chan.valid = 0; in_chan.req_type = REQ_SAMPLE; in_chan.now_ms = 0;
    in_chan.sample_data = 0; in_chan.link_ready = 0; in_chan.send_ok = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // disabled: everything reports disabled
    send_request(REQ_SAMPLE, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0);
    send_request(REQ_POLL, 32'd10, 0, 1, 1, 0);
    send_request(REQ_TELE, 32'd10, 0, 1, 1, 0);
    send_request(REQ_FLUSH, 32'd10, 0, 1, 0, 0);
    send_request(3'd7, 32'hFFFF_FFFF, 0, 0, 0, 0);
    go_idle();

    write_reg(REG_ENABLE, 20'd1);
    write_reg(REG_ATTEMPT, 20'd0);
    write_reg(REG_RETRY, 20'd0);
    write_reg(REG_BEAT, 20'd1);
    // due time lands on zero: reads as none scheduled
    send_request(REQ_SAMPLE, 32'd0, 64'h0, 1, 1, 0);
    send_request(REQ_POLL, 32'd0, 0, 0, 1, 0);
    send_request(REQ_POLL, 32'd1, 0, 1, 1, 0);
    send_request(REQ_TELE, 32'd2, 0, 1, 0, 0);
    send_request(REQ_TELE, 32'd3, 0, 1, 0, 0);
    send_request(REQ_TELE, 32'd4, 0, 1, 0, 0);
    send_request(REQ_TELE, 32'd5, 0, 1, 0, 0);
    send_request(REQ_TELE, 32'd6, 0, 1, 0, 0);
    send_request(REQ_POLL, 32'd40000, 0, 1, 1, 0);
    send_request(REQ_TELE, 32'd40001, 0, 1, 1, 0);
    send_request(REQ_TELE, 32'd40002, 0, 1, 1, 0);
    send_request(REQ_BEAT, 32'd40003, 0, 1, 1, 0);
    send_request(REQ_POLL, 32'hFFFF_FFF0, 0, 1, 1, 0);
    send_request(3'd5, 32'd7, 64'h1234, 1, 1, 0);
    send_request(3'd6, 32'd8, 64'h1234, 1, 1, 0);
    go_idle();

    write_reg(REG_ATTEMPT, 20'hFFFFF);
    write_reg(REG_RETRY, 20'hFFFFF);
    write_reg(REG_BEAT, 20'hFFFFF);
    clock_ms = 32'h7FFF_F000;
    // overflow the ring, with the receiver holding off at the start
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 70; i++)
        send_request(REQ_SAMPLE, step_time(), rand64(), 1, 1, 0);
    join
    send_request(REQ_POLL, clock_ms + 32'h0010_0000, 0, 1, 1, 0);
    send_request(REQ_TELE, clock_ms, 0, 1, 1, 0);
    go_idle();

    write_reg(REG_ATTEMPT, 20'd500);
    write_reg(REG_RETRY, 20'd1500);
    write_reg(REG_BEAT, 20'd30000);
    random_phase(85, 35);
    go_idle();

    write_reg(REG_ENABLE, 20'd0);
    random_phase(20, 30);
    go_idle();
    write_reg(REG_ENABLE, 20'd1);
    write_reg(REG_ATTEMPT, 20'd3);
    write_reg(REG_RETRY, 20'd0);
    write_reg(REG_BEAT, 20'd1);
    random_phase(85, 40);
    go_idle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
src/brq_pkg.sv
src/brq_if.sv
src/brq_front.sv
src/brq_back.sv
src/batched_retry_queue_with_backoff.sv
tb/sv/tb_batched_retry_queue_with_backoff.sv
